>>> hw/rtl/gf2alu_pkg.sv
// ---------------------------------------------------------------------------
// GF(2) polynomial ALU package
// Shared constants, the operation code type and the divisor lead-term helper.
// ---------------------------------------------------------------------------
package gf2alu_pkg;

   localparam int OP_W       = 2;
   localparam int OPERAND_W  = 32;
   localparam int RESULT_W   = 63;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_QUO = 2'd2,
      OP_REM = 2'd3
   } op_type;

   // One-hot mask of the highest set bit, found with a five-level OR smear.
   function automatic logic [OPERAND_W-1:0] top_onehot(input logic [OPERAND_W-1:0] v);
      logic [OPERAND_W-1:0] smear;
      smear = v >> 1;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
      return v & ~smear;
   endfunction

endpackage

>>> hw/rtl/gf2alu_step.sv
// ---------------------------------------------------------------------------
// GF(2) polynomial ALU shift-and-XOR step
// One bit of carry-less multiplication or of long division per call.
// ---------------------------------------------------------------------------
module gf2alu_step #(
   parameter int WIDTH = 32
) (
   input  gf2alu_pkg::op_type     op,
   input  logic [2*WIDTH-2:0]     acc,
   input  logic [WIDTH-1:0]       areg,
   input  logic [WIDTH-1:0]       divisor,
   input  logic [WIDTH-1:0]       tmask,
   output logic [2*WIDTH-2:0]     acc_next,
   output logic [WIDTH-1:0]       areg_next
);
   import gf2alu_pkg::*;

   logic               is_div;
   logic [2*WIDTH-2:0] shifted;
   logic [2*WIDTH-2:0] addend;
   logic               sel;

   // Multiply takes operand A's bits from the top and adds B on a one.
   // Divide shifts the dividend into the remainder and subtracts the
   // divisor whenever the remainder reaches the divisor's degree; the
   // quotient bits fill operand A's register from below.
   always_comb begin
      is_div  = (op == OP_QUO) || (op == OP_REM);
      shifted = {acc[2*WIDTH-3:0], is_div & areg[WIDTH-1]};
      sel     = is_div ? |(shifted[WIDTH-1:0] & tmask) : areg[WIDTH-1];
      addend  = '0;
      if (sel) begin
         addend[WIDTH-1:0] = divisor;
      end
      acc_next  = shifted ^ addend;
      areg_next = {areg[WIDTH-2:0], sel};
   end

endmodule

>>> hw/rtl/gf2_polynomial_alu_unit.sv
// ---------------------------------------------------------------------------
// GF(2) polynomial ALU
// Add, carry-less multiply, quotient and remainder of two polynomials.
// ---------------------------------------------------------------------------
// Add and zero-divisor items skip the run state and go from accept to the
// finishing state; multiply, quotient and remainder first pass through the
// run state, where the shared shift-and-XOR unit handles one coefficient bit
// per cycle. The finishing state registers the result once the output is
// free. One item at a time; the next is accepted once the result is registered.
// Synchronous active-high reset empties the sequencer and the result register.
module gf2_polynomial_alu_unit #(
   parameter int POLY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // op [1:0], operand_a [33:2], operand_b [65:34], zero fill [71:66]
   input  logic [gf2alu_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result [62:0], div_by_zero [63]
   output logic [gf2alu_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import gf2alu_pkg::*;

   localparam int CNT_W = $clog2(POLY_WIDTH);
   localparam int ACC_W = 2 * POLY_WIDTH - 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   op_type                 op_ff, op_in;
   logic                   dz_ff, dz_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [POLY_WIDTH-1:0]  areg_ff, areg_in;
   logic [POLY_WIDTH-1:0]  b_ff, b_in;
   logic [POLY_WIDTH-1:0]  tmask_ff, tmask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   op_type                 req_op;
   logic [POLY_WIDTH-1:0]  req_a;
   logic [POLY_WIDTH-1:0]  req_b;
   logic [OPERAND_W-1:0]   req_b_ext;
   logic [OPERAND_W-1:0]   b_lead;
   logic                   req_is_div;
   logic                   req_dz;
   logic [ACC_W-1:0]       step_acc;
   logic [POLY_WIDTH-1:0]  step_areg;
   logic [RESULT_W-1:0]    result;
   logic                   out_free;

   assign req_op     = op_type'(req_tdata[OP_W-1:0]);
   assign req_a      = req_tdata[OP_W +: POLY_WIDTH];
   assign req_b      = req_tdata[OP_W + OPERAND_W +: POLY_WIDTH];
   assign req_is_div = (req_op == OP_QUO) || (req_op == OP_REM);
   assign req_dz     = req_is_div && (req_b == '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      req_b_ext                   = '0;
      req_b_ext[POLY_WIDTH-1:0]   = req_b;
      b_lead                      = top_onehot(req_b_ext);
   end

   gf2alu_step #(
      .WIDTH     (POLY_WIDTH)
   ) u_step (
      .op        (op_ff),
      .acc       (acc_ff),
      .areg      (areg_ff),
      .divisor   (b_ff),
      .tmask     (tmask_ff),
      .acc_next  (step_acc),
      .areg_next (step_areg)
   );

   // The quotient ends up in operand A's register; everything else in acc.
   always_comb begin
      result = '0;
      if (op_ff == OP_QUO) begin
         result[POLY_WIDTH-1:0] = areg_ff;
      end else begin
         result[ACC_W-1:0] = acc_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      dz_in        = dz_ff;
      acc_in       = acc_ff;
      areg_in      = areg_ff;
      b_in         = b_ff;
      tmask_in     = tmask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_op;
               dz_in    = req_dz;
               b_in     = req_b;
               tmask_in = b_lead[POLY_WIDTH-1:0];
               cnt_in   = CNT_W'(POLY_WIDTH - 1);
               acc_in   = '0;
               areg_in  = req_dz ? '0 : req_a;
               if (req_op == OP_ADD) begin
                  acc_in[POLY_WIDTH-1:0] = req_a ^ req_b;
               end
               if ((req_op == OP_ADD) || req_dz) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            acc_in  = step_acc;
            areg_in = step_areg;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dz_ff, result};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      dz_ff       <= dz_in;
      acc_ff      <= acc_in;
      areg_ff     <= areg_in;
      b_ff        <= b_in;
      tmask_ff    <= tmask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sequencer still ready after taking an item");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (cnt_ff != '0) |=>
         (state_ff == ST_RUN) && (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("step counter did not advance by one");

   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[RSP_DATA_W-1] |-> (rsp_data_ff[RESULT_W-1:0] == '0))
      else $error("zero-divisor item carries a nonzero result");

   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result registered outside the finishing state");

endmodule
